/* hdl/scpa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpa_pkg
// shared widths, status codes and built-in pool tables of the pool allocator
// ----------------------------------------------------------------------------
package scpa_pkg;

   localparam int REG_COUNT  = 8;
   localparam int SIZE_W     = 16;
   localparam int SLOT_W     = 8;
   localparam int STATUS_W   = 3;
   localparam int POOL_OUT_W = 3;
   localparam int CSR_IDX_W  = 3;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_IRQ     = 3'd1,
      ST_NOFIT   = 3'd2,
      ST_EMPTY   = 3'd3,
      ST_NOMATCH = 3'd4,
      ST_FULL    = 3'd5
   } status_type;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // buffer size of each pool after reset
   function automatic logic [SIZE_W-1:0] size_reset(input int unsigned p);
      logic [SIZE_W-1:0] v;
      case (p)
         0: v = 16'd16;
         1: v = 16'd64;
         2: v = 16'd128;
         3: v = 16'd256;
         4: v = 16'd512;
         5: v = 16'd1024;
         6: v = 16'd2048;
         7: v = 16'd4096;
         default: v = '0;
      endcase
      return v;
   endfunction

   // built-in number of slots of each pool
   function automatic int unsigned builtin_count(input int unsigned p);
      int unsigned c;
      case (p)
         0: c = 200;
         1: c = 100;
         2: c = 50;
         3: c = 10;
         4: c = 10;
         5: c = 10;
         6: c = 3;
         7: c = 3;
         default: c = 0;
      endcase
      return c;
   endfunction

   // built-in count clamped to the slots a pool can hold
   function automatic int unsigned pool_capacity(input int unsigned p,
                                                 input int unsigned slots);
      int unsigned c;
      c = builtin_count(p);
      return (c > slots) ? slots : c;
   endfunction

endpackage

/* hdl/scpa_select.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpa_select
// finds the first pool that fits an allocate or matches a free
// ----------------------------------------------------------------------------
module scpa_select #(
   parameter int POOL_COUNT = 8,
   parameter int PW         = 3
) (
   input  logic [scpa_pkg::SIZE_W-1:0] pool_size [POOL_COUNT],
   input  logic                        operation,
   input  logic [scpa_pkg::SIZE_W-1:0] byte_count,
   output logic                        hit,
   output logic [PW-1:0]               pool
);

   logic [POOL_COUNT-1:0] match;

   always_comb begin
      for (int p = 0; p < POOL_COUNT; p++) begin
         if (operation == scpa_pkg::OP_FREE) begin
            match[p] = (byte_count == pool_size[p]);
         end else begin
            match[p] = (byte_count <= pool_size[p]);
         end
      end
   end

   // lowest matching pool wins
   always_comb begin
      hit  = 1'b0;
      pool = '0;
      for (int p = POOL_COUNT - 1; p >= 0; p--) begin
         if (match[p]) begin
            hit  = 1'b1;
            pool = PW'(p);
         end
      end
   end

endmodule

/* hdl/scpa_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpa_store
// per-pool counter memory with valid bits and the shared return stack memory
// ----------------------------------------------------------------------------
module scpa_store #(
   parameter int POOL_COUNT     = 8,
   parameter int SLOTS_PER_POOL = 256,
   parameter int PW             = 3,
   parameter int CW             = 9,
   parameter int SIW            = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cnt_rd_en,
   input  logic [PW-1:0]               cnt_rd_pool,
   output logic [CW-1:0]               cnt_fresh,
   output logic [CW-1:0]               cnt_depth,
   input  logic                        cnt_wr_en,
   input  logic [PW-1:0]               cnt_wr_pool,
   input  logic [CW-1:0]               cnt_wr_fresh,
   input  logic [CW-1:0]               cnt_wr_depth,
   input  logic                        stk_rd_en,
   input  logic [PW-1:0]               stk_rd_pool,
   input  logic [SIW-1:0]              stk_rd_idx,
   output logic [scpa_pkg::SLOT_W-1:0] stk_rd_data,
   input  logic                        stk_wr_en,
   input  logic [PW-1:0]               stk_wr_pool,
   input  logic [SIW-1:0]              stk_wr_idx,
   input  logic [scpa_pkg::SLOT_W-1:0] stk_wr_data
);

   localparam int STK_DEPTH = POOL_COUNT * SLOTS_PER_POOL;
   localparam int AW        = (STK_DEPTH > 1) ? $clog2(STK_DEPTH) : 1;

   typedef struct packed {
      logic [CW-1:0] fresh;
      logic [CW-1:0] depth;
   } cnt_entry_type;

   cnt_entry_type              cnt_mem [POOL_COUNT];
   logic [scpa_pkg::SLOT_W-1:0] stk_mem [STK_DEPTH];

   logic [POOL_COUNT-1:0]       cnt_vld_ff;
   cnt_entry_type               cnt_rd_ff;
   logic                        cnt_rd_vld_ff;
   logic [PW-1:0]               cnt_rd_pool_ff;
   logic [scpa_pkg::SLOT_W-1:0] stk_rd_ff;
   logic [CW-1:0]               cap_tab [POOL_COUNT];
   logic [AW-1:0]               stk_rd_addr;
   logic [AW-1:0]               stk_wr_addr;

   always_comb begin
      for (int p = 0; p < POOL_COUNT; p++) begin
         cap_tab[p] = CW'(scpa_pkg::pool_capacity(p, SLOTS_PER_POOL));
      end
   end

   // an entry never written reads as its reset value
   assign cnt_fresh = cnt_rd_vld_ff ? cnt_rd_ff.fresh : cap_tab[cnt_rd_pool_ff];
   assign cnt_depth = cnt_rd_vld_ff ? cnt_rd_ff.depth : '0;

   always_ff @(posedge clock) begin
      if (cnt_wr_en) begin
         cnt_mem[cnt_wr_pool] <= '{fresh: cnt_wr_fresh, depth: cnt_wr_depth};
      end
      if (cnt_rd_en) begin
         cnt_rd_ff      <= cnt_mem[cnt_rd_pool];
         cnt_rd_pool_ff <= cnt_rd_pool;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_vld_ff    <= '0;
         cnt_rd_vld_ff <= 1'b0;
      end else begin
         if (cnt_wr_en) begin
            cnt_vld_ff[cnt_wr_pool] <= 1'b1;
         end
         if (cnt_rd_en) begin
            cnt_rd_vld_ff <= cnt_vld_ff[cnt_rd_pool];
         end
      end
   end

   // each pool owns a contiguous block of the stack memory
   assign stk_rd_addr = AW'(stk_rd_pool) * AW'(SLOTS_PER_POOL) + AW'(stk_rd_idx);
   assign stk_wr_addr = AW'(stk_wr_pool) * AW'(SLOTS_PER_POOL) + AW'(stk_wr_idx);

   always_ff @(posedge clock) begin
      if (stk_wr_en) begin
         stk_mem[stk_wr_addr] <= stk_wr_data;
      end
      if (stk_rd_en) begin
         stk_rd_ff <= stk_mem[stk_rd_addr];
      end
   end

   assign stk_rd_data = stk_rd_ff;

endmodule

/* hdl/size_class_pool_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_class_pool_allocator
// size-class buffer pool allocator with per-pool lifo free lists
// ----------------------------------------------------------------------------
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+------------------------
//  request   | req_operation, req_in_interrupt,        | taken when start && !busy
//            | req_byte_count, req_freed_slot          |
//  response  | rsp_status, rsp_pool_index,             | rsp_valid for one cycle,
//            | rsp_granted_slot                        | no back-pressure
//  csr       | csr_index, csr_wdata                    | written when csr_wr_en
//
//  a request reads the pool's counter entry when it is taken; in S_CNT the
//  entry is updated and the return stack memory is written or read; an
//  allocate that pops a returned slot passes through S_STK for the
//  registered stack read data
//  the response shows in the cycle busy drops, so a new request may be
//  started in that same cycle
//  synchronous reset restores the pool sizes and marks all counter entries
//  unwritten; no clearing pass is needed
// ----------------------------------------------------------------------------
module size_class_pool_allocator #(
   parameter int POOL_COUNT     = 8,
   parameter int SLOTS_PER_POOL = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   // request
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_operation,
   input  logic                           req_in_interrupt,
   input  logic [scpa_pkg::SIZE_W-1:0]    req_byte_count,
   input  logic [scpa_pkg::SLOT_W-1:0]    req_freed_slot,
   // response
   output logic                           rsp_valid,
   output logic [scpa_pkg::STATUS_W-1:0]  rsp_status,
   output logic [scpa_pkg::POOL_OUT_W-1:0] rsp_pool_index,
   output logic [scpa_pkg::SLOT_W-1:0]    rsp_granted_slot,
   // configuration
   input  logic                           csr_wr_en,
   input  logic [scpa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [scpa_pkg::SIZE_W-1:0]    csr_wdata
);

   localparam int PW  = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
   localparam int CW  = $clog2(SLOTS_PER_POOL + 1);
   localparam int SIW = $clog2(SLOTS_PER_POOL);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CNT,
      S_STK
   } state_type;

   state_type                         state_ff;
   logic                              op_ff;
   logic                              irq_ff;
   logic                              hit_ff;
   logic [PW-1:0]                     pool_ff;
   logic [scpa_pkg::SLOT_W-1:0]       slot_ff;
   logic                              rsp_valid_ff;
   scpa_pkg::status_type              rsp_status_ff;
   logic [scpa_pkg::POOL_OUT_W-1:0]   rsp_pool_ff;
   logic [scpa_pkg::SLOT_W-1:0]       rsp_slot_ff;

   logic [scpa_pkg::SIZE_W-1:0]       pool_size [POOL_COUNT];
   logic                              req_accept;
   logic                              sel_hit;
   logic [PW-1:0]                     sel_pool;

   logic [CW-1:0]                     cnt_fresh;
   logic [CW-1:0]                     cnt_depth;
   logic [CW-1:0]                     cap_sel;
   logic                              pool_full;
   logic                              cnt_wr_en;
   logic [CW-1:0]                     fresh_in;
   logic [CW-1:0]                     depth_in;
   logic                              stk_rd_en;
   logic                              stk_wr_en;
   logic [scpa_pkg::SLOT_W-1:0]       stk_rd_data;
   logic                              goto_stk;
   scpa_pkg::status_type              status_in;
   logic [scpa_pkg::POOL_OUT_W-1:0]   pool_in;
   logic [scpa_pkg::SLOT_W-1:0]       slot_in;

   // pool size registers; pools beyond the register list have size zero
   for (genvar p = 0; p < POOL_COUNT; p++) begin : g_size
      if (p < scpa_pkg::REG_COUNT) begin : g_reg
         logic [scpa_pkg::SIZE_W-1:0] size_ff;
         always_ff @(posedge clock) begin
            if (reset) begin
               size_ff <= scpa_pkg::size_reset(p);
            end else if (csr_wr_en && csr_index == scpa_pkg::CSR_IDX_W'(p)) begin
               size_ff <= csr_wdata;
            end
         end
         assign pool_size[p] = size_ff;
      end else begin : g_fixed
         assign pool_size[p] = '0;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign req_accept = start && !busy;

   // pool search runs on the live request so the counter read starts at once
   scpa_select #(
      .POOL_COUNT (POOL_COUNT),
      .PW         (PW)
   ) u_select (
      .pool_size  (pool_size),
      .operation  (req_operation),
      .byte_count (req_byte_count),
      .hit        (sel_hit),
      .pool       (sel_pool)
   );

   scpa_store #(
      .POOL_COUNT     (POOL_COUNT),
      .SLOTS_PER_POOL (SLOTS_PER_POOL),
      .PW             (PW),
      .CW             (CW),
      .SIW            (SIW)
   ) u_store (
      .clock        (clock),
      .reset        (reset),
      .cnt_rd_en    (req_accept),
      .cnt_rd_pool  (sel_pool),
      .cnt_fresh    (cnt_fresh),
      .cnt_depth    (cnt_depth),
      .cnt_wr_en    (cnt_wr_en),
      .cnt_wr_pool  (pool_ff),
      .cnt_wr_fresh (fresh_in),
      .cnt_wr_depth (depth_in),
      .stk_rd_en    (stk_rd_en),
      .stk_rd_pool  (pool_ff),
      .stk_rd_idx   (SIW'(depth_in)),
      .stk_rd_data  (stk_rd_data),
      .stk_wr_en    (stk_wr_en),
      .stk_wr_pool  (pool_ff),
      .stk_wr_idx   (SIW'(cnt_depth)),
      .stk_wr_data  (slot_ff)
   );

   // capacity of the selected pool
   always_comb begin
      cap_sel = '0;
      for (int p = 0; p < POOL_COUNT; p++) begin
         if (pool_ff == PW'(p)) begin
            cap_sel = CW'(scpa_pkg::pool_capacity(p, SLOTS_PER_POOL));
         end
      end
   end

   // fresh plus returned slots already at capacity: no room for a free
   assign pool_full = ({1'b0, cnt_fresh} + {1'b0, cnt_depth}) >= {1'b0, cap_sel};

   // read-modify-write decision while the counter entry is on the read port
   always_comb begin
      cnt_wr_en = 1'b0;
      stk_rd_en = 1'b0;
      stk_wr_en = 1'b0;
      goto_stk  = 1'b0;
      fresh_in  = cnt_fresh;
      depth_in  = cnt_depth;
      status_in = scpa_pkg::ST_OK;
      pool_in   = scpa_pkg::POOL_OUT_W'(pool_ff);
      slot_in   = '0;
      if (state_ff == S_CNT) begin
         if (irq_ff) begin
            status_in = scpa_pkg::ST_IRQ;
            pool_in   = '0;
         end else if (!hit_ff) begin
            status_in = (op_ff == scpa_pkg::OP_FREE) ? scpa_pkg::ST_NOMATCH
                                                     : scpa_pkg::ST_NOFIT;
            pool_in   = '0;
         end else if (op_ff == scpa_pkg::OP_ALLOC) begin
            if (cnt_depth != '0) begin
               // returned slots go out first, newest on top
               depth_in  = cnt_depth - CW'(1);
               cnt_wr_en = 1'b1;
               stk_rd_en = 1'b1;
               goto_stk  = 1'b1;
            end else if (cnt_fresh != '0) begin
               // fresh slots count down from the top
               fresh_in  = cnt_fresh - CW'(1);
               cnt_wr_en = 1'b1;
               slot_in   = scpa_pkg::SLOT_W'(fresh_in);
            end else begin
               status_in = scpa_pkg::ST_EMPTY;
            end
         end else begin
            if (pool_full) begin
               status_in = scpa_pkg::ST_FULL;
            end else begin
               depth_in  = cnt_depth + CW'(1);
               cnt_wr_en = 1'b1;
               stk_wr_en = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  state_ff <= S_CNT;
                  op_ff    <= req_operation;
                  irq_ff   <= req_in_interrupt;
                  hit_ff   <= sel_hit;
                  pool_ff  <= sel_pool;
                  slot_ff  <= req_freed_slot;
               end
            end
            S_CNT: begin
               if (goto_stk) begin
                  state_ff <= S_STK;
               end else begin
                  state_ff      <= S_IDLE;
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_in;
                  rsp_pool_ff   <= pool_in;
                  rsp_slot_ff   <= slot_in;
               end
            end
            S_STK: begin
               state_ff      <= S_IDLE;
               rsp_valid_ff  <= 1'b1;
               rsp_status_ff <= scpa_pkg::ST_OK;
               rsp_pool_ff   <= scpa_pkg::POOL_OUT_W'(pool_ff);
               rsp_slot_ff   <= stk_rd_data;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_pool_index   = rsp_pool_ff;
   assign rsp_granted_slot = rsp_slot_ff;

endmodule

/* hdl/scpa_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpa_checker
// port-level checks of request and response timing of the pool allocator
// ----------------------------------------------------------------------------
module scpa_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            req_in_interrupt,
   input logic                            rsp_valid,
   input logic [scpa_pkg::STATUS_W-1:0]   rsp_status,
   input logic [scpa_pkg::POOL_OUT_W-1:0] rsp_pool_index,
   input logic [scpa_pkg::SLOT_W-1:0]     rsp_granted_slot
);

   // a request taken in interrupt context is refused with ST_IRQ from S_CNT
   a_irq_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_in_interrupt) |->
         ##2 (rsp_valid && rsp_status == scpa_pkg::ST_IRQ))
      else $error("interrupt refusal not answered on time");

   // the response comes exactly when the block goes idle
   a_done_resp: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_valid)
      else $error("busy dropped without a response");

   // one response per request, never two in a row
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   // failures carry no slot; no pool is named when none was selected
   a_fail_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != scpa_pkg::ST_OK) |->
         (rsp_granted_slot == '0 &&
          (rsp_status == scpa_pkg::ST_EMPTY || rsp_status == scpa_pkg::ST_FULL ||
           rsp_pool_index == '0)))
      else $error("failed response carries slot or pool");

endmodule

bind size_class_pool_allocator scpa_checker u_scpa_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_in_interrupt (req_in_interrupt),
   .rsp_valid        (rsp_valid),
   .rsp_status       (rsp_status),
   .rsp_pool_index   (rsp_pool_index),
   .rsp_granted_slot (rsp_granted_slot)
);
